### hw/rtl/schrev_pkg.sv
// Shared types and constants for the Schroeder reverberator.
`default_nettype none
package schrev_pkg;
  localparam int CombDepthDef    = 2048;
  localparam int AllpassDepthDef = 1024;
  localparam int CombLinesDef    = 4;
  localparam int AllpassLinesDef = 2;

  localparam logic signed [23:0] S24Max = 24'sh7FFFFF;
  localparam logic signed [23:0] S24Min = -24'sh800000;
  localparam logic [14:0] DampMax = 15'd32112;
  localparam logic [16:0] MixMax  = 17'd32768;
  localparam logic [14:0] AllpassGain = 15'd17367;

  localparam logic [2:0] RegDamp   = 3'd0;
  localparam logic [2:0] RegDry    = 3'd1;
  localparam logic [2:0] RegWet    = 3'd2;
  localparam logic [2:0] RegSpread = 3'd3;
  localparam logic [2:0] RegRate   = 3'd4;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SPAN, ST_SPAN2,
    ST_CRD, ST_CMUL, ST_CLP, ST_CFB, ST_CWR,
    ST_AVG, ST_ARD, ST_AMUL, ST_AWR,
    ST_MIX, ST_MIX2, ST_OUT
  } state_t;

  function automatic logic [14:0] comb_gain(input logic [1:0] k);
    case (k)
      2'd0:    comb_gain = 15'd24314;
      2'd1:    comb_gain = 15'd24707;
      2'd2:    comb_gain = 15'd25100;
      default: comb_gain = 15'd25494;
    endcase
  endfunction

  function automatic logic [10:0] base_len(input logic [2:0] s);
    case (s)
      3'd0:    base_len = 11'd1447;
      3'd1:    base_len = 11'd1559;
      3'd2:    base_len = 11'd1663;
      3'd3:    base_len = 11'd1787;
      3'd4:    base_len = 11'd421;
      default: base_len = 11'd631;
    endcase
  endfunction

  // floor((v + 2^14) / 2^15) on a 48-bit signed value
  function automatic logic signed [32:0] rnd15(input logic signed [47:0] v);
    logic signed [47:0] t;
    t = v + 48'sd16384;
    rnd15 = t[47:15];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [33:0] v);
    if (v > 34'(S24Max)) sat24 = S24Max;
    else if (v < 34'(S24Min)) sat24 = S24Min;
    else sat24 = v[23:0];
  endfunction
endpackage
`default_nettype wire

### hw/rtl/schroeder_reverb_top.sv
// Schroeder reverberator top level: four damped combs, two allpass stages, dry/wet mix.
//
// Input stream s_axis_*: one 16-bit signed Q1.15 sample per word.
// Output stream m_axis_*: one 16-bit signed Q1.15 reverberated sample per input word.
// Config port: cfg_we/cfg_index/cfg_data; the user must write it only while idle, which the
// block itself does not enforce; a write to length_spread or rate_ratio recomputes the six spans.
// One shared multiplier runs under a sequencer: each word passes through read, multiply,
// low-pass, feedback and write for each comb, an average, read, multiply and write for
// each allpass, then mix and output; no new word is taken until the last one reaches the output register.
// s_axis_tready is high only while idle. The result sits in an output register
// until taken; the next word is accepted meanwhile and, once finished, waits
// for that register, so a stalled receiver holds one result and one finished
// item before the input stops.
// After reset a clearing pass over all 4*COMB_DEPTH comb entries zeroes the delay stores
// (allpass store is cleared in the same pass); no item is accepted meanwhile.
`default_nettype none
module schroeder_reverb_top
  import schrev_pkg::*;
#(
  parameter int COMB_DEPTH    = CombDepthDef,
  parameter int ALLPASS_DEPTH = AllpassDepthDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [15:0] sample_in
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // [15:0] sample_out
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [18:0] cfg_data
);
  localparam int CW = $clog2(COMB_DEPTH);
  localparam int AW = $clog2(ALLPASS_DEPTH);
  localparam int CAW = CW + 2;
  localparam int AAW = AW + 1;
  localparam int SW = CW + 1;

  logic signed [23:0] cmem [4*COMB_DEPTH];
  logic signed [23:0] amem [2*ALLPASS_DEPTH];

  state_t state, state_next;
  logic [14:0] damp;
  logic [15:0] dry, wet;
  logic [7:0]  spread;
  logic [18:0] ratio;
  logic [SW-1:0] span [6];
  logic [SW-1:0] pos  [6];
  logic signed [23:0] lp [4];
  logic [CAW-1:0] clr;
  logic [2:0] k;
  logic signed [15:0] x;
  logic signed [23:0] dly, damped, diffuse;
  logic signed [25:0] sum;
  logic signed [47:0] acc;
  logic signed [47:0] prod;
  logic signed [24:0] ma;
  logic signed [19:0] mb;
  logic [31:0] slen;
  logic signed [23:0] crd, ard;
  logic [15:0] yout;
  logic ovalid;

  wire [16:0] dsat = (dry > 16'(MixMax)) ? MixMax : {1'b0, dry};
  wire [16:0] wsat = (wet > 16'(MixMax)) ? MixMax : {1'b0, wet};
  wire [14:0] dcl  = (damp > DampMax) ? DampMax : damp;
  wire [1:0]  kc   = k[1:0];
  wire        ka   = k[0];
  wire [SW-1:0] pc = pos[kc];
  wire [SW-1:0] pa = pos[3'd4 + {2'b0, ka}];

  // shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      ST_SPAN:  begin ma = 25'({1'b0, base_len(k)}); mb = 20'(ratio); end
      ST_CMUL:  begin ma = 25'(crd); mb = 20'(17'd32768 - {2'b0, dcl}); end
      ST_CLP:   begin ma = 25'(lp[kc]); mb = 20'({2'b0, dcl}); end
      ST_CFB, ST_CWR: begin ma = 25'(damped); mb = 20'({2'b0, comb_gain(kc)}); end
      ST_AMUL, ST_AWR: begin ma = 25'(ard); mb = 20'({2'b0, AllpassGain}); end
      ST_MIX:   begin ma = 25'(x); mb = 20'({1'b0, dsat}); end
      ST_MIX2, ST_OUT: begin ma = 25'(diffuse); mb = 20'({1'b0, wsat}); end
      default: ;
    endcase
  end
  assign prod = 48'(ma) * 48'(mb);

  always_ff @(posedge clk) begin
    crd <= cmem[{kc, pc[CW-1:0]}];
    ard <= amem[{ka, pa[AW-1:0]}];
    if (state == ST_CLEAR) begin
      cmem[clr] <= '0;
      if (clr < CAW'(2*ALLPASS_DEPTH)) amem[clr[AAW-1:0]] <= '0;
    end else if (state == ST_CWR) begin
      cmem[{kc, pc[CW-1:0]}] <= sat24(34'(x) + 34'(rnd15(prod)));
    end else if (state == ST_AWR) begin
      amem[{ka, pa[AW-1:0]}] <= sat24(34'(diffuse) + 34'(rnd15(prod)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr == CAW'(4*COMB_DEPTH-1)) state_next = ST_SPAN;
      ST_IDLE: begin
        if (cfg_we && (cfg_index == RegSpread || cfg_index == RegRate))
          state_next = ST_SPAN;
        else if (s_axis_tvalid && s_axis_tready) state_next = ST_CRD;
      end
      ST_SPAN:  state_next = ST_SPAN2;
      ST_SPAN2: state_next = (k == 3'd5) ? ST_IDLE : ST_SPAN;
      ST_CRD:   state_next = ST_CMUL;
      ST_CMUL:  state_next = ST_CLP;
      ST_CLP:   state_next = ST_CFB;
      ST_CFB:   state_next = ST_CWR;
      ST_CWR:   state_next = (kc == 2'd3) ? ST_AVG : ST_CRD;
      ST_AVG:   state_next = ST_ARD;
      ST_ARD:   state_next = ST_AMUL;
      ST_AMUL:  state_next = ST_AWR;
      ST_AWR:   state_next = ka ? ST_MIX : ST_ARD;
      ST_MIX:   state_next = ST_MIX2;
      ST_MIX2:  state_next = ST_OUT;
      ST_OUT:   if (!ovalid || m_axis_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state == ST_IDLE) && !cfg_we;
  assign m_axis_tvalid = ovalid;
  assign m_axis_tdata  = yout;

  wire [SW-1:0] cap  = (k < 3'd4) ? SW'(COMB_DEPTH) : SW'(ALLPASS_DEPTH);
  wire [2:0]    kadj = (k < 3'd4) ? k : k - 3'd4;
  wire signed [47:0] acc_sum = acc + prod;
  wire signed [32:0] yr = rnd15(acc_sum);
  wire signed [24:0] apd = 25'(ard) - 25'(diffuse);

  always_ff @(posedge clk) begin
    if (rst) begin
      damp <= 15'd7864; dry <= 16'd23593; wet <= 16'd9175;
      spread <= '0; ratio <= 19'd65536;
      clr <= '0; k <= '0; ovalid <= 1'b0;
      for (int i = 0; i < 6; i++) pos[i] <= '0;
      for (int i = 0; i < 4; i++) lp[i] <= '0;
    end else begin
      if (m_axis_tready) ovalid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          RegDamp:   damp <= cfg_data[14:0];
          RegDry:    dry <= cfg_data[15:0];
          RegWet:    wet <= cfg_data[15:0];
          RegSpread: spread <= cfg_data[7:0];
          RegRate:   ratio <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_CLEAR: begin clr <= clr + 1'b1; k <= '0; end
        ST_IDLE: begin
          k <= '0;
          sum <= '0;
          x <= s_axis_tdata;
        end
        ST_SPAN: slen <= 32'(prod[34:16]) + 32'(spread) * 32'(kadj + 3'd1);
        ST_SPAN2: begin
          if (slen == 0) span[k] <= SW'(1);
          else if (slen > 32'(cap)) span[k] <= cap;
          else span[k] <= slen[SW-1:0];
          if (pos[k] >= ((slen == 0) ? SW'(1) : (slen > 32'(cap)) ? cap : slen[SW-1:0]))
            pos[k] <= '0;
          k <= (k == 3'd5) ? 3'd0 : k + 3'd1;
        end
        ST_CMUL: begin dly <= crd; acc <= prod; end
        ST_CLP: begin
          damped <= sat24(34'(rnd15(acc + prod)));
          lp[kc] <= sat24(34'(rnd15(acc + prod)));
        end
        ST_CWR: begin
          sum <= sum + 26'(dly);
          pos[kc] <= (pc + 1'b1 >= span[kc]) ? '0 : pc + 1'b1;
          k <= (kc == 2'd3) ? 3'd0 : k + 3'd1;
        end
        ST_AVG: begin
          diffuse <= sat24(34'((sum + 26'sd2) >>> 2));
        end
        ST_AWR: begin
          diffuse <= sat24(34'(apd));
          pos[3'd4 + {2'b0, ka}] <= (pa + 1'b1 >= span[3'd4 + {2'b0, ka}]) ? '0 : pa + 1'b1;
          k <= ka ? 3'd0 : 3'd1;
        end
        ST_MIX: acc <= prod;
        ST_OUT: begin
          if (!ovalid || m_axis_tready) begin
            if (yr > 33'sd32767) yout <= 16'h7FFF;
            else if (yr < -33'sd32768) yout <= 16'h8000;
            else yout <= yr[15:0];
            ovalid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // allpass read is registered from the ARD set-up address; ard valid in AMUL
  // (memory read is registered each cycle from current addresses)

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_axis_tready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (state == ST_CRD)) else $error("no start");
endmodule
`default_nettype wire

### tb/tb_schroeder_reverb_top.sv
// Testbench for the Schroeder reverberator: directed, configuration, backpressure, random and nominal sample tests.
`default_nettype none
module tb_schroeder_reverb_top
  import schrev_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CD = CombDepthDef;
  localparam int AD = AllpassDepthDef;
  localparam int LIMIT = 2_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [18:0] cfg_data = '0;

  schroeder_reverb_top uut (.*);

  always #6 clk = ~clk;

  // predictor state
  longint comb_mem [CD*4];
  longint ap_mem [AD*2];
  int comb_pos [4];
  int ap_pos [2];
  longint comb_lp [4];
  int comb_len [4];
  int ap_len [2];
  int damp_q, dry_q, wet_q, spread_q, rate_q;
  const int comb_fb [4] = '{24314, 24707, 25100, 25494};
  const int comb_nominal_len [4] = '{1447, 1559, 1663, 1787};
  const int ap_base [2] = '{421, 631};

  logic [15:0] expected_samples [$];
  int errors = 0;
  bit stall_on = 1'b1;
  bit calm = 1'b0;
  int long_hold = 0;
  longint cycles = 0;

  function automatic longint rnd_q15(longint v);
    longint t;
    t = v + 16384;
    return t >>> 15;
  endfunction

  function automatic longint clip24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic int span_len(int base, int stage, int cap);
    longint n;
    n = (longint'(base) * rate_q) >>> 16;
    n += longint'(spread_q) * (stage + 1);
    if (n < 1) n = 1;
    if (n > cap) n = cap;
    return int'(n);
  endfunction

  function automatic void respan();
    for (int k = 0; k < 4; k++) begin
      comb_len[k] = span_len(comb_nominal_len[k], k, CD);
      if (comb_pos[k] >= comb_len[k]) comb_pos[k] = 0;
    end
    for (int k = 0; k < 2; k++) begin
      ap_len[k] = span_len(ap_base[k], k, AD);
      if (ap_pos[k] >= ap_len[k]) ap_pos[k] = 0;
    end
  endfunction

  function automatic logic [15:0] reverb_sample(logic [15:0] raw);
    longint x, d, dr, wt, acc, diff, dl, dm, nx, y;
    int p;
    x = longint'($signed(raw));
    d = (damp_q > 32112) ? 32112 : damp_q;
    dr = (dry_q > 32768) ? 32768 : dry_q;
    wt = (wet_q > 32768) ? 32768 : wet_q;
    acc = 0;
    for (int k = 0; k < 4; k++) begin
      p = comb_pos[k];
      if (p >= comb_len[k]) p = 0;
      dl = comb_mem[k*CD + p];
      dm = clip24(rnd_q15(dl * (32768 - d) + comb_lp[k] * d));
      comb_lp[k] = dm;
      comb_mem[k*CD + p] = clip24(x + rnd_q15(dm * comb_fb[k]));
      p++;
      if (p >= comb_len[k]) p = 0;
      comb_pos[k] = p;
      acc += dl;
    end
    diff = clip24((acc + 2) >>> 2);
    for (int k = 0; k < 2; k++) begin
      p = ap_pos[k];
      if (p >= ap_len[k]) p = 0;
      dl = ap_mem[k*AD + p];
      nx = clip24(diff + rnd_q15(dl * 17367));
      diff = clip24(dl - diff);
      ap_mem[k*AD + p] = nx;
      p++;
      if (p >= ap_len[k]) p = 0;
      ap_pos[k] = p;
    end
    y = rnd_q15(dr * x + wt * diff);
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    return y[15:0];
  endfunction

  task automatic send_sample(logic [15:0] v);
    int gap;
    if (stall_on && !calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= v;
    do @(posedge clk); while (!s_axis_tready);
    expected_samples.push_back(reverb_sample(v));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [18:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegDamp: damp_q = val[14:0];
      RegDry: dry_q = val[15:0];
      RegWet: wet_q = val[15:0];
      RegSpread: begin spread_q = val[7:0]; respan(); end
      RegRate: begin rate_q = val; respan(); end
      default: ;
    endcase
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [15:0] audio_sample();
    case ($urandom_range(0, 4))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 255)) - 16'd128;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic test_extremes();
    logic [15:0] dir [10] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001,
                              16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h5555};
    foreach (dir[i]) send_sample(dir[i]);
    drain();
  endtask

  task automatic test_config_extremes();
    write_reg(RegDry, 19'd32768);
    write_reg(RegWet, 19'd32768);
    write_reg(RegDamp, 19'd0);
    write_reg(RegRate, 19'd0);
    for (int i = 0; i < 4; i++) send_sample(i[0] ? 16'h7FFF : 16'h8000);
    write_reg(RegSpread, 19'd255);
    write_reg(RegRate, 19'd262144);
    write_reg(RegDamp, 19'h7FFF);
    write_reg(RegDry, 19'hFFFF);
    write_reg(RegWet, 19'hFFFF);
    write_reg(3'd7, 19'h7FFFF);
    write_reg(3'd5, 19'd1);
    for (int i = 0; i < 6; i++) send_sample(audio_sample());
    write_reg(RegDry, 19'd0);
    write_reg(RegWet, 19'd0);
    for (int i = 0; i < 3; i++) send_sample(audio_sample());
    drain();
  endtask

  // short spans so the delay lines wrap many times
  task automatic test_random(int n);
    write_reg(RegRate, 19'($urandom_range(0, 2000)));
    write_reg(RegSpread, 19'($urandom_range(1, 20)));
    write_reg(RegDamp, 19'($urandom_range(0, 32767)));
    write_reg(RegDry, 19'($urandom_range(0, 32768)));
    write_reg(RegWet, 19'($urandom_range(16000, 32768)));
    for (int i = 0; i < n; i++) send_sample(audio_sample());
  endtask

  task automatic test_backpressure();
    long_hold = 300;
    for (int i = 0; i < 6; i++) send_sample(audio_sample());
    drain();
  endtask

  task automatic test_nominal(int n);
    write_reg(RegRate, 19'd65536);
    write_reg(RegSpread, 19'd0);
    write_reg(RegDamp, 19'd7864);
    for (int i = 0; i < n; i++) send_sample(audio_sample());
  endtask

  // receiver
  always @(posedge clk) begin
    if (long_hold > 0) begin
      m_axis_tready <= 1'b0;
      long_hold <= long_hold - 1;
    end else if (stall_on && !calm && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_samples.size() == 0) begin
        $display("%t unexpected sample_out: expected none, actual %0d", $realtime,
                 $signed(m_axis_tdata));
        errors++;
      end else begin
        if (m_axis_tdata !== expected_samples[0]) begin
          $display("%t sample_out mismatch: expected %0d, actual %0d", $realtime,
                   $signed(expected_samples[0]), $signed(m_axis_tdata));
          errors++;
        end
        void'(expected_samples.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    foreach (comb_mem[i]) comb_mem[i] = 0;
    foreach (ap_mem[i]) ap_mem[i] = 0;
    foreach (comb_pos[i]) begin comb_pos[i] = 0; comb_lp[i] = 0; end
    foreach (ap_pos[i]) ap_pos[i] = 0;
    damp_q = 7864; dry_q = 23593; wet_q = 9175; spread_q = 0; rate_q = 65536;
    respan();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_config_extremes();
    test_backpressure();
    test_random(500);
    test_random(300);
    test_nominal(250);
    calm = 1'b1;
    test_random(150);
    drain();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
hw/rtl/schrev_pkg.sv
hw/rtl/schroeder_reverb_top.sv
tb/tb_schroeder_reverb_top.sv
